// ===== rtl/cdecc_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the CD-ROM ECC P/Q generator.
package cdecc_pkg;

   // Sector geometry (bytes from the header onward)
   localparam logic [11:0] SECTOR_LAST   = 12'd2235;
   localparam logic [11:0] HEADER_BYTES  = 12'd4;

   // P code: 86 columns of 24 bytes, processed as 43 column pairs
   localparam logic [5:0]  P_PAIR_LAST   = 6'd42;
   localparam logic [5:0]  P_MINOR_LAST  = 6'd23;
   localparam logic [8:0]  P_MAJORS      = 9'd86;
   localparam logic [11:0] P_MULT        = 12'd2;
   localparam logic [11:0] P_INC         = 12'd86;
   localparam logic [11:0] P_SPAN        = 12'd2064;
   localparam logic [8:0]  P_BASE        = 9'd0;

   // Q code: 52 diagonals of 43 bytes, processed as 26 diagonal pairs
   localparam logic [5:0]  Q_PAIR_LAST   = 6'd25;
   localparam logic [5:0]  Q_MINOR_LAST  = 6'd42;
   localparam logic [8:0]  Q_MAJORS      = 9'd52;
   localparam logic [11:0] Q_MULT        = 12'd86;
   localparam logic [11:0] Q_INC         = 12'd88;
   localparam logic [11:0] Q_SPAN        = 12'd2236;
   localparam logic [8:0]  Q_BASE        = 9'd172;

   // Parity store and result words
   localparam logic [8:0]  PARITY_BYTES  = 9'd276;
   localparam logic [8:0]  PARITY_LAST   = 9'd275;
   localparam logic [3:0]  WORD_BYTES    = 4'd8;
   localparam logic [3:0]  TAIL_BYTES    = 4'd4;

   // Block select
   localparam logic BLK_P = 1'b0;
   localparam logic BLK_Q = 1'b1;

   // Write-back select: which parity byte of a lane pair is written
   localparam logic [1:0] WB_PV_A = 2'd0;
   localparam logic [1:0] WB_PV_B = 2'd1;
   localparam logic [1:0] WB_PE_A = 2'd2;
   localparam logic [1:0] WB_PE_B = 2'd3;

   // GF(2^8), polynomial 0x11D
   localparam logic [7:0] GF_POLY_LOW = 8'h1D;
   localparam logic [7:0] GF_INV3     = 8'hF4;

   typedef struct packed {
      logic        load_we;     // write one sector byte
      logic [11:0] load_addr;
      logic        start;       // set up a lane pair
      logic        first;       // first pair of the block
      logic        blk;         // BLK_P or BLK_Q
      logic        issue;       // read both lanes and step addresses
      logic        par_we;      // parity write-back
      logic [1:0]  par_sel;
      logic        par_rd;      // parity read for output
      logic [8:0]  par_addr;
      logic        push;        // move assembled word to output register
      logic        last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [7:0] gf_times2(input logic [7:0] v);
      gf_times2 = {v[6:0], 1'b0} ^ (v[7] ? GF_POLY_LOW : 8'h00);
   endfunction

   // Division by 3 = multiplication by the constant 0xF4
   function automatic logic [7:0] gf_div3(input logic [7:0] v);
      logic [7:0] a;
      logic [7:0] acc;
      a   = v;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (GF_INV3[i]) begin
            acc = acc ^ a;
         end
         a = gf_times2(a);
      end
      gf_div3 = acc;
   endfunction

endpackage

// ===== rtl/cdecc_if.sv =====
// Valid/ready channel interfaces for sector bytes, parity words and the control register.
interface cdecc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface cdecc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] parity_word;
   logic [3:0]  valid_bytes;
   logic        last;
   modport source (output valid, output parity_word, output valid_bytes, output last,
                   input ready);
   modport sink   (input valid, input parity_word, input valid_bytes, input last,
                   output ready);
endinterface

interface cdecc_csr_if;
   logic valid;
   logic ready;
   logic zero_header;
   modport source (output valid, output zero_header, input ready);
   modport sink   (input valid, input zero_header, output ready);
endinterface

// ===== rtl/cdecc_datapath.sv =====
// Datapath: sector store, two-lane RS accumulators, parity store and output word register.
module cdecc_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  cdecc_pkg::cmd_type     cmd,
   output cdecc_pkg::status_type  status,
   input  logic [7:0]             req_data_byte,
   input  logic                   csr_we,
   input  logic                   csr_zero_header,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [63:0]            rsp_parity_word,
   output logic [3:0]             rsp_valid_bytes,
   output logic                   rsp_last
);

   logic [7:0]  sector_mem [0:2235];
   logic [7:0]  parity_mem [0:275];

   logic        zero_header_ff;
   logic [11:0] base_ff, base_in;
   logic [11:0] addr_a_ff, addr_a_in;
   logic [11:0] addr_b_ff, addr_b_in;
   logic [11:0] mult, inc, span;
   logic [7:0]  rd_a_ff, rd_b_ff;
   logic        zero_a_ff, zero_b_ff;
   logic        vld_ff;
   logic [7:0]  ea_a_ff, eb_a_ff, ea_b_ff, eb_b_ff;
   logic [7:0]  t_a, t_b;
   logic [7:0]  pv_a, pv_b, par_wdata;
   logic [7:0]  prd_ff;
   logic [2:0]  ppos_ff;
   logic        pvld_ff;
   logic [63:0] asm_ff;
   logic        rsp_valid_ff;
   logic [63:0] word_ff;
   logic [3:0]  vb_ff;
   logic        last_ff;

   function automatic logic [11:0] step_addr(input logic [11:0] a, input logic [11:0] d,
                                             input logic [11:0] s);
      logic [11:0] sum;
      sum = a + d;
      step_addr = (sum >= s) ? sum - s : sum;
   endfunction

   always_comb begin
      mult = (cmd.blk == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_MULT : cdecc_pkg::P_MULT;
      inc  = (cmd.blk == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_INC  : cdecc_pkg::P_INC;
      span = (cdecc_pkg::BLK_Q == cmd.blk) ? cdecc_pkg::Q_SPAN : cdecc_pkg::P_SPAN;
      base_in   = cmd.first ? 12'd0 : base_ff + mult;
      addr_a_in = step_addr(addr_a_ff, inc, span);
      addr_b_in = step_addr(addr_b_ff, inc, span);
      t_a  = zero_a_ff ? 8'h00 : rd_a_ff;
      t_b  = zero_b_ff ? 8'h00 : rd_b_ff;
      pv_a = cdecc_pkg::gf_div3(cdecc_pkg::gf_times2(ea_a_ff) ^ eb_a_ff);
      pv_b = cdecc_pkg::gf_div3(cdecc_pkg::gf_times2(ea_b_ff) ^ eb_b_ff);
      unique case (cmd.par_sel)
         cdecc_pkg::WB_PV_A: par_wdata = pv_a;
         cdecc_pkg::WB_PV_B: par_wdata = pv_b;
         cdecc_pkg::WB_PE_A: par_wdata = pv_a ^ eb_a_ff;
         cdecc_pkg::WB_PE_B: par_wdata = pv_b ^ eb_b_ff;
         default:            par_wdata = pv_a;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         zero_header_ff <= 1'b0;
         vld_ff         <= 1'b0;
         pvld_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            zero_header_ff <= csr_zero_header;
         end
         vld_ff  <= cmd.issue;
         pvld_ff <= cmd.par_rd;
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sector store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         sector_mem[cmd.load_addr] <= req_data_byte;
      end
      if (cmd.issue) begin
         rd_a_ff <= sector_mem[addr_a_ff];
         rd_b_ff <= sector_mem[addr_b_ff];
      end
   end

   // address generators and accumulators
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         base_ff   <= base_in;
         addr_a_ff <= base_in;
         addr_b_ff <= base_in + 12'd1;
         ea_a_ff   <= 8'h00;
         eb_a_ff   <= 8'h00;
         ea_b_ff   <= 8'h00;
         eb_b_ff   <= 8'h00;
      end else begin
         if (cmd.issue) begin
            addr_a_ff <= addr_a_in;
            addr_b_ff <= addr_b_in;
            zero_a_ff <= zero_header_ff && (addr_a_ff < cdecc_pkg::HEADER_BYTES);
            zero_b_ff <= zero_header_ff && (addr_b_ff < cdecc_pkg::HEADER_BYTES);
         end
         if (vld_ff) begin
            ea_a_ff <= cdecc_pkg::gf_times2(ea_a_ff ^ t_a);
            eb_a_ff <= eb_a_ff ^ t_a;
            ea_b_ff <= cdecc_pkg::gf_times2(ea_b_ff ^ t_b);
            eb_b_ff <= eb_b_ff ^ t_b;
         end
      end
   end

   // parity store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.par_we) begin
         parity_mem[cmd.par_addr] <= par_wdata;
      end
      if (cmd.par_rd) begin
         prd_ff  <= parity_mem[cmd.par_addr];
         ppos_ff <= cmd.par_addr[2:0];
      end
   end

   // word assembly and output register
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         asm_ff  <= 64'd0;
         word_ff <= asm_ff;
         vb_ff   <= cmd.last ? cdecc_pkg::TAIL_BYTES : cdecc_pkg::WORD_BYTES;
         last_ff <= cmd.last;
      end else if (pvld_ff) begin
         asm_ff[{ppos_ff, 3'b000} +: 8] <= prd_ff;
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parity_word  = word_ff;
   assign rsp_valid_bytes  = vb_ff;
   assign rsp_last         = last_ff;

   a_addr_in_span: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (addr_a_ff < span) && (addr_b_ff < span))
      else $error("sector read address beyond code span");

   a_clear_not_during_accum: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !vld_ff)
      else $error("accumulator cleared while a read is still landing");

   a_push_after_bytes: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !pvld_ff)
      else $error("word pushed while a parity byte is still arriving");

endmodule

// ===== rtl/cdecc_ctrl.sv =====
// Controller: load sequencing, P/Q pair loops, parity write-back and word output.
module cdecc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdecc_pkg::status_type status,
   output cdecc_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_LOAD,
      S_START,
      S_RUN,
      S_DRAIN,
      S_WB,
      S_OUT_RD,
      S_OUT_WAIT,
      S_OUT_PUSH
   } state_type;

   state_type   state_ff;
   logic [11:0] byte_cnt_ff;
   logic        blk_ff;
   logic [5:0]  pair_ff;
   logic [5:0]  minor_ff;
   logic [1:0]  step_ff;
   logic [8:0]  out_addr_ff;

   logic [5:0]  pair_last;
   logic [5:0]  minor_last;
   logic [8:0]  wb_addr;

   always_comb begin
      pair_last  = (blk_ff == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_PAIR_LAST
                                                : cdecc_pkg::P_PAIR_LAST;
      minor_last = (blk_ff == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_MINOR_LAST
                                                : cdecc_pkg::P_MINOR_LAST;
      // base + major + (second half ? majors : 0)
      wb_addr = ((blk_ff == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_BASE : cdecc_pkg::P_BASE)
              + {2'b00, pair_ff, step_ff[0]}
              + (step_ff[1] ? ((blk_ff == cdecc_pkg::BLK_Q) ? cdecc_pkg::Q_MAJORS
                                                            : cdecc_pkg::P_MAJORS)
                            : 9'd0);
   end

   always_comb begin
      cmd           = '0;
      cmd.load_addr = byte_cnt_ff;
      cmd.blk       = blk_ff;
      cmd.first     = (pair_ff == 6'd0);
      req_ready     = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            req_ready   = 1'b1;
            cmd.load_we = req_valid;
         end
         S_START:    cmd.start = 1'b1;
         S_RUN:      cmd.issue = 1'b1;
         S_DRAIN:    cmd.issue = 1'b0;
         S_WB: begin
            cmd.par_we   = 1'b1;
            cmd.par_sel  = step_ff;
            cmd.par_addr = wb_addr;
         end
         S_OUT_RD: begin
            cmd.par_rd   = 1'b1;
            cmd.par_addr = out_addr_ff;
         end
         S_OUT_WAIT: cmd.push = 1'b0;
         S_OUT_PUSH: begin
            cmd.push = status.out_free;
            cmd.last = (out_addr_ff == cdecc_pkg::PARITY_BYTES);
         end
         default:    cmd.push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         byte_cnt_ff <= 12'd0;
         blk_ff      <= cdecc_pkg::BLK_P;
         pair_ff     <= 6'd0;
         minor_ff    <= 6'd0;
         step_ff     <= 2'd0;
         out_addr_ff <= 9'd0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (byte_cnt_ff == cdecc_pkg::SECTOR_LAST) begin
                     byte_cnt_ff <= 12'd0;
                     blk_ff      <= cdecc_pkg::BLK_P;
                     pair_ff     <= 6'd0;
                     state_ff    <= S_START;
                  end else begin
                     byte_cnt_ff <= byte_cnt_ff + 12'd1;
                  end
               end
            end
            S_START: begin
               minor_ff <= 6'd0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               if (minor_ff == minor_last) begin
                  state_ff <= S_DRAIN;
               end else begin
                  minor_ff <= minor_ff + 6'd1;
               end
            end
            S_DRAIN: begin
               step_ff  <= 2'd0;
               state_ff <= S_WB;
            end
            S_WB: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == cdecc_pkg::WB_PE_B) begin
                  if (pair_ff == pair_last) begin
                     pair_ff <= 6'd0;
                     if (blk_ff == cdecc_pkg::BLK_P) begin
                        blk_ff   <= cdecc_pkg::BLK_Q;
                        state_ff <= S_START;
                     end else begin
                        out_addr_ff <= 9'd0;
                        state_ff    <= S_OUT_RD;
                     end
                  end else begin
                     pair_ff  <= pair_ff + 6'd1;
                     state_ff <= S_START;
                  end
               end
            end
            S_OUT_RD: begin
               out_addr_ff <= out_addr_ff + 9'd1;
               if ((out_addr_ff[2:0] == 3'd7) || (out_addr_ff == cdecc_pkg::PARITY_LAST)) begin
                  state_ff <= S_OUT_WAIT;
               end
            end
            S_OUT_WAIT: state_ff <= S_OUT_PUSH;
            S_OUT_PUSH: begin
               if (status.out_free) begin
                  state_ff <= (out_addr_ff == cdecc_pkg::PARITY_BYTES) ? S_LOAD : S_OUT_RD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.par_we |-> (cmd.par_addr < cdecc_pkg::PARITY_BYTES))
      else $error("parity write-back address out of range");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (minor_ff <= minor_last))
      else $error("minor counter ran past the code length");

   a_last_returns_to_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && cmd.last) |=> (state_ff == S_LOAD) && (byte_cnt_ff == 12'd0))
      else $error("final word pushed without returning to load");

endmodule

// ===== rtl/cdrom_ecc_pq_generator_core.sv =====
// Top level of the CD-ROM ECC P/Q parity generator: controller plus datapath.
//
//  channel  dir  word                                      handshake
//  -------  ---  ----------------------------------------  ---------
//  req_if   in   data_byte[7:0], sector bytes 0..2235      valid/ready
//  rsp_if   out  parity_word[63:0], valid_bytes[3:0], last valid/ready
//  csr_if   in   zero_header                               valid/ready
//
//  Load takes one byte per cycle (single write port of the sector store).
//  P runs 43 column pairs, two lanes on the two sector read ports, each pair
//  a setup step, 24 reads, a drain step and 4 write-backs; Q runs 26 diagonal
//  pairs the same way with 43 reads each. Output reads the parity store one byte a
//  cycle within a word; each full word or the 4-byte tail is then pushed, and a
//  push waits until the output register is free.
//  Reset is synchronous and clears control only; no clearing pass over the stores.
//  req_if is ready only while loading. The last word sits in the output register
//  while the next sector loads; an rsp stall holds the word assembly loop.
module cdrom_ecc_pq_generator_core (
   input  logic             clock,
   input  logic             reset,
   cdecc_req_if.sink        req_if,
   cdecc_rsp_if.source      rsp_if,
   cdecc_csr_if.sink        csr_if
);

   cdecc_pkg::cmd_type    cmd;
   cdecc_pkg::status_type status;

   // register write always taken
   assign csr_if.ready = 1'b1;

   cdecc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cdecc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_data_byte   (req_if.data_byte),
      .csr_we          (csr_if.valid),
      .csr_zero_header (csr_if.zero_header),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_parity_word (rsp_if.parity_word),
      .rsp_valid_bytes (rsp_if.valid_bytes),
      .rsp_last        (rsp_if.last)
   );

endmodule

// ===== bench/cdecc_parity_checker.sv =====
// Checker for the CD-ROM ECC P/Q generator: predicts parity words and compares them.
`timescale 1ns / 100ps

module cdecc_parity_checker (
   input  logic  clock,
   input  logic  reset,
   cdecc_req_if  req_mon,
   cdecc_rsp_if  rsp_mon,
   cdecc_csr_if  csr_mon,
   output int    fail_count,
   output int    words_pending
);

   localparam int SECTOR_SIZE  = 2236;
   localparam int PARITY_SIZE  = 276;
   localparam int WORDS_PER_SECTOR = 35;
   localparam int HEADER_SIZE  = 4;
   localparam logic [7:0] GF_REDUCE = 8'h1D;   // x^8 + x^4 + x^3 + x^2 + 1, low byte
   localparam logic [7:0] INV_OF_3  = 8'hF4;

   typedef struct {
      logic [63:0] parity_word;
      logic [3:0]  valid_bytes;
      logic        last;
   } parity_word_type;

   logic [7:0]      sector_img [0:SECTOR_SIZE-1];
   logic [7:0]      parity_img [0:PARITY_SIZE-1];
   int              load_pos;
   logic            hdr_zero;
   int              errors;
   parity_word_type parity_words_due[$];

   assign fail_count = errors;

   function automatic logic [7:0] alpha_mul(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ ({8{v[7]}} & GF_REDUCE);
   endfunction

   function automatic logic [7:0] div_by3(input logic [7:0] v);
      logic [7:0] prod;
      logic [7:0] pow;
      prod = 8'h00;
      pow  = v;
      for (int b = 0; b < 8; b++) begin
         if (INV_OF_3[b]) prod ^= pow;
         pow = alpha_mul(pow);
      end
      return prod;
   endfunction

   function automatic logic [7:0] fetch(input int idx);
      if (hdr_zero && idx < HEADER_SIZE) return 8'h00;
      return sector_img[idx];
   endfunction

   // one RS(n, n-2) code pass: P columns or Q diagonals
   function automatic void encode_block(input int base, input int majors, input int minors,
                                        input int mult, input int inc);
      int         span;
      int         idx;
      logic [7:0] ea, eb, t, pv;
      span = majors * minors;
      for (int major = 0; major < majors; major++) begin
         idx = (major >> 1) * mult + (major & 1);
         ea  = 8'h00;
         eb  = 8'h00;
         for (int minor = 0; minor < minors; minor++) begin
            t   = fetch(idx);
            idx = idx + inc;
            if (idx >= span) idx = idx - span;
            ea  = alpha_mul(ea ^ t);
            eb  = eb ^ t;
         end
         pv = div_by3(alpha_mul(ea) ^ eb);
         parity_img[base + major]          = pv;
         parity_img[base + major + majors] = pv ^ eb;
      end
   endfunction

   function automatic void predict_sector_parity();
      parity_word_type w;
      int              n;
      encode_block(0,   86, 24,  2, 86);
      encode_block(172, 52, 43, 86, 88);
      for (int k = 0; k < WORDS_PER_SECTOR; k++) begin
         n = PARITY_SIZE - 8 * k;
         if (n > 8) n = 8;
         w.parity_word = 64'h0;
         for (int j = 0; j < n; j++) w.parity_word[8*j +: 8] = parity_img[8*k + j];
         w.valid_bytes = 4'(n);
         w.last        = (k == WORDS_PER_SECTOR - 1);
         parity_words_due.push_back(w);
      end
   endfunction

   always @(posedge clock) begin
      parity_word_type exp_w;
      if (reset) begin
         load_pos = 0;
         hdr_zero = 1'b0;
         errors   = 0;
         parity_words_due.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) hdr_zero = csr_mon.zero_header;

         if (req_mon.valid && req_mon.ready) begin
            sector_img[load_pos] = req_mon.data_byte;
            load_pos++;
            if (load_pos == SECTOR_SIZE) begin
               predict_sector_parity();
               load_pos = 0;
            end
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (parity_words_due.size() == 0) begin
               $error("parity word with none expected: parity_word %h", rsp_mon.parity_word);
               errors++;
            end else begin
               exp_w = parity_words_due.pop_front();
               if (rsp_mon.parity_word !== exp_w.parity_word) begin
                  $error("parity_word: expected %h, got %h",
                         exp_w.parity_word, rsp_mon.parity_word);
                  errors++;
               end
               if (rsp_mon.valid_bytes !== exp_w.valid_bytes) begin
                  $error("valid_bytes: expected %0d, got %0d",
                         exp_w.valid_bytes, rsp_mon.valid_bytes);
                  errors++;
               end
               if (rsp_mon.last !== exp_w.last) begin
                  $error("last: expected %b, got %b", exp_w.last, rsp_mon.last);
                  errors++;
               end
            end
         end
      end
      words_pending <= parity_words_due.size();
   end

endmodule

// ===== bench/tb_cdrom_ecc_pq_generator_core.sv =====
// Testbench top for the CD-ROM ECC P/Q generator: sector stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_cdrom_ecc_pq_generator_core;

   localparam int SECTOR_SIZE   = 2236;
   localparam int SETTLE_CYCLES = 24;      // margin while the output stage settles
   localparam int STALL_LIMIT   = 20000;   // must outlast the quiet P and Q passes

   typedef enum logic {FILL_EXTREMES, FILL_RANDOM} fill_kind_type;

   logic clock;
   logic reset;
   bit   calm;            // set: no gaps on either side for a stretch
   int   fail_count;
   int   words_pending;
   int   idle_cycles;

   cdecc_req_if req_if();
   cdecc_rsp_if rsp_if();
   cdecc_csr_if csr_if();

   cdrom_ecc_pq_generator_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   cdecc_parity_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .csr_mon       (csr_if),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none, some short, a few long. None at all while calm.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one byte, holding valid high until it is taken. Valid is only
   // lowered when a gap follows, so back-to-back words keep it high.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // One full sector from the header onward. The extremes fill repeats
   // 00/FF/80/01 plus the low index byte through every position, header
   // included, so the zero-header option has nonzero bytes to mask.
   task automatic send_sector(input fill_kind_type kind);
      logic [7:0] b;
      int         r;
      for (int i = 0; i < SECTOR_SIZE; i++) begin
         if (i % 256 == 0) calm = ($urandom_range(0, 3) == 0);
         if (kind == FILL_EXTREMES) begin
            case (i % 5)
               0:       b = 8'h00;
               1:       b = 8'hFF;
               2:       b = 8'h80;
               3:       b = 8'h01;
               default: b = 8'(i);
            endcase
         end else begin
            r = $urandom_range(0, 19);
            if (r == 0)      b = 8'h00;
            else if (r == 1) b = 8'hFF;
            else             b = 8'($urandom_range(0, 255));
         end
         send_byte(b);
      end
      req_if.valid <= 1'b0;
      calm = 1'b0;
   endtask

   task automatic write_zero_header(input logic v);
      csr_if.valid       <= 1'b1;
      csr_if.zero_header <= v;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   // All 35 words of the sector back, then let the output stage settle
   // before anything touches the control register.
   task automatic wait_drained();
      do @(posedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: ready low for a random gap, then high for a random run.
   initial begin
      int hold;
      rsp_if.ready <= 1'b0;
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog: any accepted word on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("cdrom_ecc_pq_generator_core: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_if.valid       <= 1'b0;
      req_if.data_byte   <= 8'h00;
      csr_if.valid       <= 1'b0;
      csr_if.zero_header <= 1'b0;
      reset              <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // header kept, register at its reset value
      send_sector(FILL_EXTREMES);
      wait_drained();

      // same content with the header masked
      write_zero_header(1'b1);
      send_sector(FILL_EXTREMES);
      wait_drained();

      // random content under both settings; the store is overwritten in place
      write_zero_header(1'b0);
      send_sector(FILL_RANDOM);
      wait_drained();

      write_zero_header(1'b1);
      send_sector(FILL_RANDOM);
      wait_drained();

      if (fail_count == 0 && words_pending == 0) begin
         $display("cdrom_ecc_pq_generator_core: match");
      end else begin
         $display("cdrom_ecc_pq_generator_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== cdrom_ecc_pq_generator_core.f =====
rtl/cdecc_pkg.sv
rtl/cdecc_if.sv
rtl/cdecc_datapath.sv
rtl/cdecc_ctrl.sv
rtl/cdrom_ecc_pq_generator_core.sv
bench/cdecc_parity_checker.sv
bench/tb_cdrom_ecc_pq_generator_core.sv
